FILE: rtl/octn_pkg.sv
// Shared widths, types and helpers for the octahedral normal encoder.
// No dependencies; used by the top level octahedral_normal_encoder_unit.
package octn_pkg;

    localparam int IN_W  = 16;
    localparam int S_W   = IN_W + 1;
    localparam int OUT_W = 16;

    typedef logic [S_W-1:0] t_mag;

    typedef enum logic {
        QM_UNORM = 1'b0,
        QM_SNORM = 1'b1
    } t_qmode;

    function automatic t_mag abs_mag(input logic [IN_W-1:0] v);
        logic [S_W-1:0] e;
        e = {v[IN_W-1], v};
        return v[IN_W-1] ? (~e + 1'b1) : e;
    endfunction

endpackage

FILE: rtl/octahedral_normal_encoder_unit.sv
// Top level of the octahedral normal encoder: projection, fold, quantization and division.
// Depends on octn_pkg for widths, the quantization mode type and the magnitude helper.

// The unit takes one normal per cycle unless the output stalls, and returns its
// two octahedral codes. Three stages form the magnitudes, the L1 norm with the
// lower-hemisphere fold, and the quantization dividend; CODE_BITS stages of a
// restoring divider then produce one quotient bit each; a last register applies
// the SNORM sign and the zero-vector code (UNORM centre, SNORM zero). When the output
// beat is not taken, the whole pipeline holds and no input beat is accepted.
// The mode register should be written only while the pipeline is empty.
module octahedral_normal_encoder_unit #(
    parameter int CODE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [octn_pkg::IN_W-1:0]    i_nx,
    input  logic [octn_pkg::IN_W-1:0]    i_ny,
    input  logic [octn_pkg::IN_W-1:0]    i_nz,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [octn_pkg::OUT_W-1:0]   o_code_u,
    output logic [octn_pkg::OUT_W-1:0]   o_code_v
);

    localparam int QB    = CODE_BITS;
    localparam int DEN_W = octn_pkg::S_W + 1;
    localparam int DW    = DEN_W + QB + 1;
    localparam logic [QB-1:0] UMAX   = {QB{1'b1}};
    localparam logic [QB-1:0] SMAX   = {1'b0, {(QB-1){1'b1}}};
    localparam logic [QB-1:0] CENTRE = {1'b1, {(QB-1){1'b0}}};

    typedef struct packed {
        logic             valid;
        logic             zero;
        logic             neg_u;
        logic             neg_v;
        logic [DEN_W-1:0] den;
        logic [DW-1:0]    rem_u;
        logic [DW-1:0]    rem_v;
        logic [QB-1:0]    q_u;
        logic [QB-1:0]    q_v;
    } t_div;

    octn_pkg::t_qmode r_qmode;
    logic             en;

    logic             r_a_valid;
    octn_pkg::t_mag   r_ax, r_ay, r_az;
    logic             r_a_sx, r_a_sy, r_a_zneg;

    logic             r_b_valid;
    octn_pkg::t_mag   r_b_s, r_b_mu, r_b_mv;
    logic             r_b_nu, r_b_nv, r_b_zero;
    octn_pkg::t_mag   n_b_s, n_b_mu, n_b_mv;

    logic [DEN_W-1:0] base_u, base_v;
    t_div             n_c;
    t_div             r_dv [0:QB];
    t_div             n_dv [1:QB];

    logic             r_out_valid;
    logic [octn_pkg::OUT_W-1:0] r_code_u, r_code_v;
    logic [QB-1:0]    fin_u, fin_v;

    assign en          = !r_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_code_u    = r_code_u;
    assign o_code_v    = r_code_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qmode <= octn_pkg::QM_UNORM;
        end else if (i_cfg_valid) begin
            r_qmode <= octn_pkg::t_qmode'(i_cfg_data);
        end
    end

    // Magnitudes and signs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax     <= octn_pkg::abs_mag(i_nx);
            r_ay     <= octn_pkg::abs_mag(i_ny);
            r_az     <= octn_pkg::abs_mag(i_nz);
            r_a_sx   <= i_nx[octn_pkg::IN_W-1];
            r_a_sy   <= i_ny[octn_pkg::IN_W-1];
            r_a_zneg <= i_nz[octn_pkg::IN_W-1];
        end
    end

    // L1 norm and fold onto the upper square.
    always_comb begin
        n_b_s  = r_ax + r_ay + r_az;
        n_b_mu = r_a_zneg ? (n_b_s - r_ay) : r_ax;
        n_b_mv = r_a_zneg ? (n_b_s - r_ax) : r_ay;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_s    <= n_b_s;
            r_b_mu   <= n_b_mu;
            r_b_mv   <= n_b_mv;
            r_b_nu   <= r_a_sx;
            r_b_nv   <= r_a_sy;
            r_b_zero <= (n_b_s == '0);
        end
    end

    // Quantization dividend and divisor.
    always_comb begin
        base_u = r_b_nu ? ({1'b0, r_b_s} - {1'b0, r_b_mu}) : ({1'b0, r_b_s} + {1'b0, r_b_mu});
        base_v = r_b_nv ? ({1'b0, r_b_s} - {1'b0, r_b_mv}) : ({1'b0, r_b_s} + {1'b0, r_b_mv});
        n_c       = '0;
        n_c.valid = r_b_valid;
        n_c.zero  = r_b_zero;
        n_c.neg_u = r_b_nu;
        n_c.neg_v = r_b_nv;
        n_c.den   = {r_b_s, 1'b0};
        if (r_qmode == octn_pkg::QM_UNORM) begin
            n_c.rem_u = DW'(base_u) * DW'(UMAX) + DW'(r_b_s);
            n_c.rem_v = DW'(base_v) * DW'(UMAX) + DW'(r_b_s);
        end else begin
            n_c.rem_u = DW'({r_b_mu, 1'b0}) * DW'(SMAX) + DW'(r_b_s);
            n_c.rem_v = DW'({r_b_mv, 1'b0}) * DW'(SMAX) + DW'(r_b_s);
        end
    end

    // Restoring divider, one quotient bit per stage, most significant first.
    for (genvar k = 0; k < QB; k++) begin : g_div
        localparam int BIT = QB - 1 - k;
        logic [DW-1:0] dsh;
        assign dsh = DW'(r_dv[k].den) << BIT;
        always_comb begin
            n_dv[k+1] = r_dv[k];
            if (r_dv[k].rem_u >= dsh) begin
                n_dv[k+1].rem_u    = r_dv[k].rem_u - dsh;
                n_dv[k+1].q_u[BIT] = 1'b1;
            end
            if (r_dv[k].rem_v >= dsh) begin
                n_dv[k+1].rem_v    = r_dv[k].rem_v - dsh;
                n_dv[k+1].q_v[BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QB; k++) begin
                r_dv[k].valid <= 1'b0;
            end
        end else if (en) begin
            r_dv[0] <= n_c;
            for (int k = 1; k <= QB; k++) begin
                r_dv[k] <= n_dv[k];
            end
        end
    end

    // Sign, centre code and output register.
    always_comb begin
        if (r_dv[QB].zero) begin
            fin_u = (r_qmode == octn_pkg::QM_UNORM) ? CENTRE : '0;
            fin_v = fin_u;
        end else if (r_qmode == octn_pkg::QM_UNORM) begin
            fin_u = r_dv[QB].q_u;
            fin_v = r_dv[QB].q_v;
        end else begin
            fin_u = r_dv[QB].neg_u ? (~r_dv[QB].q_u + 1'b1) : r_dv[QB].q_u;
            fin_v = r_dv[QB].neg_v ? (~r_dv[QB].q_v + 1'b1) : r_dv[QB].q_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_dv[QB].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_code_u <= octn_pkg::OUT_W'(fin_u);
            r_code_v <= octn_pkg::OUT_W'(fin_v);
        end
    end

endmodule

FILE: verif/tb.sv
// Self-checking testbench for octahedral_normal_encoder_unit: random and directed normals
// in both quantization modes, with a built-in encoder predictor and randomized handshakes.
// Depends on rtl/octn_pkg.sv and rtl/octahedral_normal_encoder_unit.sv.
module tb;

    localparam int CODE_BITS  = 16;
    localparam int QUIET_TAIL = 80;
    localparam int HOLD_AT    = 100;
    localparam int HOLD_LEN   = 90;

    typedef struct packed {
        logic [octn_pkg::OUT_W-1:0] u;
        logic [octn_pkg::OUT_W-1:0] v;
    } t_codes;

    typedef struct {
        logic                      is_write;
        octn_pkg::t_qmode          mode;
        logic [octn_pkg::IN_W-1:0] x;
        logic [octn_pkg::IN_W-1:0] y;
        logic [octn_pkg::IN_W-1:0] z;
    } t_job;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_cfg_valid = 1'b0;
    logic            o_cfg_ready;
    logic            i_cfg_data = 1'b0;
    logic            i_in_valid = 1'b0;
    logic            o_in_ready;
    logic [octn_pkg::IN_W-1:0] i_nx = '0;
    logic [octn_pkg::IN_W-1:0] i_ny = '0;
    logic [octn_pkg::IN_W-1:0] i_nz = '0;
    logic            o_out_valid;
    logic            i_out_ready = 1'b0;
    logic [octn_pkg::OUT_W-1:0] o_code_u;
    logic [octn_pkg::OUT_W-1:0] o_code_v;

    t_job   pending[$];
    t_codes expected_codes[$];
    octn_pkg::t_qmode cur_mode = octn_pkg::QM_UNORM;

    int normals_sent = 0;
    int codes_seen = 0;
    int mode_writes = 0;
    int mismatches = 0;
    int total_normals = 0;
    int gap_cnt = 0;
    int stall_cnt = 0;
    int send_idle_pct = 15;
    int recv_idle_pct = 15;
    int hold_cnt = 0;
    logic hold_done = 1'b0;
    logic in_fire, cfg_fire, next_in, next_cfg;
    t_codes got;

    octahedral_normal_encoder_unit #(
        .CODE_BITS(CODE_BITS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_nx       (i_nx),
        .i_ny       (i_ny),
        .i_nz       (i_nz),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_code_u   (o_code_u),
        .o_code_v   (o_code_v)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint magnitude(input longint a);
        return (a < 0) ? -a : a;
    endfunction

    function automatic logic [octn_pkg::OUT_W-1:0] quantize_ratio(
        input longint num, input longint den, input octn_pkg::t_qmode m);
        longint q;
        if (m == octn_pkg::QM_UNORM) begin
            q = ((num + den) * ((64'sd1 << CODE_BITS) - 1) + den) / (2 * den);
        end else begin
            q = (2 * magnitude(num) * ((64'sd1 << (CODE_BITS - 1)) - 1) + den) / (2 * den);
            if (num < 0) q = -q;
        end
        q = q & ((64'sd1 << CODE_BITS) - 1);
        return q[octn_pkg::OUT_W-1:0];
    endfunction

    function automatic t_codes encode_normal(input logic [octn_pkg::IN_W-1:0] x,
                                             input logic [octn_pkg::IN_W-1:0] y,
                                             input logic [octn_pkg::IN_W-1:0] z,
                                             input octn_pkg::t_qmode m);
        longint sx, sy, sz, l1, nu, nv;
        t_codes r;
        sx = longint'($signed(x));
        sy = longint'($signed(y));
        sz = longint'($signed(z));
        l1 = magnitude(sx) + magnitude(sy) + magnitude(sz);
        if (l1 == 0) begin
            r.u = (m == octn_pkg::QM_UNORM) ? octn_pkg::OUT_W'(1 << (CODE_BITS - 1)) : '0;
            r.v = r.u;
            return r;
        end
        nu = sx;
        nv = sy;
        if (sz < 0) begin
            nu = (l1 - magnitude(sy)) * ((sx >= 0) ? 1 : -1);
            nv = (l1 - magnitude(sx)) * ((sy >= 0) ? 1 : -1);
        end
        r.u = quantize_ratio(nu, l1, m);
        r.v = quantize_ratio(nv, l1, m);
        return r;
    endfunction

    function automatic logic [octn_pkg::IN_W-1:0] random_component();
        case ($urandom_range(0, 5))
            0: return octn_pkg::IN_W'($signed($urandom_range(0, 16)) - 8);
            1: return '0;
            2: begin
                case ($urandom_range(0, 3))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'hFFFF;
                    default: return 16'h0001;
                endcase
            end
            default: return octn_pkg::IN_W'($urandom);
        endcase
    endfunction

    task automatic queue_normal(input logic [octn_pkg::IN_W-1:0] x,
                                input logic [octn_pkg::IN_W-1:0] y,
                                input logic [octn_pkg::IN_W-1:0] z);
        t_job j;
        j.is_write = 1'b0;
        j.mode = octn_pkg::QM_UNORM;
        j.x = x;
        j.y = y;
        j.z = z;
        pending.push_back(j);
        total_normals++;
    endtask

    task automatic queue_mode_write(input octn_pkg::t_qmode m);
        t_job j;
        j.is_write = 1'b1;
        j.mode = m;
        j.x = '0;
        j.y = '0;
        j.z = '0;
        pending.push_back(j);
    endtask

    task automatic queue_directed();
        queue_normal(16'sd0, 16'sd0, 16'sd0);
        queue_normal(16'sd32767, 16'sd0, 16'sd0);
        queue_normal(-16'sd32768, 16'sd0, 16'sd0);
        queue_normal(16'sd0, 16'sd32767, 16'sd0);
        queue_normal(16'sd0, -16'sd32768, 16'sd0);
        queue_normal(16'sd0, 16'sd0, 16'sd32767);
        queue_normal(16'sd0, 16'sd0, -16'sd32768);
        queue_normal(-16'sd32768, -16'sd32768, -16'sd32768);
        queue_normal(16'sd32767, 16'sd32767, 16'sd32767);
        queue_normal(16'sd0, -16'sd3, -16'sd1);
        queue_normal(-16'sd3, 16'sd0, -16'sd1);
        queue_normal(16'sd1, -16'sd2, 16'sd4);
        queue_normal(-16'sd1, 16'sd1, -16'sd1);
    endtask

    task automatic queue_random(input int n);
        for (int k = 0; k < n; k++) begin
            queue_normal(random_component(), random_component(), random_component());
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_cfg_valid <= 1'b0;
            gap_cnt = 0;
        end else begin
            in_fire  = i_in_valid && o_in_ready;
            cfg_fire = i_cfg_valid && o_cfg_ready;
            if (in_fire) begin
                expected_codes.push_back(encode_normal(i_nx, i_ny, i_nz, cur_mode));
                normals_sent++;
            end
            if (cfg_fire) begin
                cur_mode = octn_pkg::t_qmode'(i_cfg_data);
                mode_writes++;
            end
            if (!((i_in_valid && !in_fire) || (i_cfg_valid && !cfg_fire))) begin
                next_in  = 1'b0;
                next_cfg = 1'b0;
                if (gap_cnt > 0) begin
                    gap_cnt--;
                end else if (pending.size() != 0) begin
                    if (pending[0].is_write) begin
                        if (expected_codes.size() == 0) begin
                            next_cfg = 1'b1;
                            i_cfg_data <= pending[0].mode;
                            void'(pending.pop_front());
                        end
                    end else if (pending.size() > QUIET_TAIL &&
                                 $urandom_range(0, 99) < send_idle_pct) begin
                        gap_cnt = $urandom_range(1, 13) - 1;
                    end else begin
                        next_in = 1'b1;
                        i_nx <= pending[0].x;
                        i_ny <= pending[0].y;
                        i_nz <= pending[0].z;
                        void'(pending.pop_front());
                    end
                end
                i_in_valid  <= next_in;
                i_cfg_valid <= next_cfg;
            end
            if ($urandom_range(0, 63) == 0) begin
                send_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 15 * $urandom_range(1, 3);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (!hold_done && normals_sent >= HOLD_AT) begin
            hold_cnt  <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_cnt = 0;
        end else begin
            if (hold_cnt > 0) begin
                i_out_ready <= 1'b0;
            end else if (stall_cnt > 0) begin
                stall_cnt--;
                i_out_ready <= 1'b0;
            end else if (codes_seen < total_normals - QUIET_TAIL &&
                         $urandom_range(0, 99) < recv_idle_pct) begin
                stall_cnt = $urandom_range(1, 13) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
            if ($urandom_range(0, 63) == 0) begin
                recv_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 15 * $urandom_range(1, 3);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            codes_seen++;
            if (expected_codes.size() == 0) begin
                $error("code pair with nothing expected: code_u %h, code_v %h",
                       o_code_u, o_code_v);
                mismatches++;
            end else begin
                got = expected_codes.pop_front();
                if (o_code_u !== got.u) begin
                    $error("code_u: expected %h, actual %h", got.u, o_code_u);
                    mismatches++;
                end
                if (o_code_v !== got.v) begin
                    $error("code_v: expected %h, actual %h", got.v, o_code_v);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        queue_mode_write(octn_pkg::QM_UNORM);
        queue_directed();
        queue_mode_write(octn_pkg::QM_SNORM);
        queue_directed();
        queue_random(300);
        queue_mode_write(octn_pkg::QM_UNORM);
        queue_random(300);
        queue_mode_write(octn_pkg::QM_SNORM);
        queue_random(150);
        queue_mode_write(octn_pkg::QM_UNORM);
        queue_random(200);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || i_in_valid || i_cfg_valid || expected_codes.size() != 0)
            @(posedge i_clk);
        repeat (CODE_BITS + 8) @(posedge i_clk);

        $display("Encoded %0d normals across %0d mode writes in both quantization modes,",
                 normals_sent, mode_writes);
        $display("with a long output hold-off; %0d code pairs were checked.", codes_seen);
        if (mismatches == 0 && expected_codes.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
